/* rtl/split_half_running_statistics_macros.svh */
// Assertion macros for the split-half running statistics block.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef SPLIT_HALF_RUNNING_STATISTICS_MACROS_SVH
`define SPLIT_HALF_RUNNING_STATISTICS_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SHRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("split_half_running_statistics: check failed");

// Antecedent implies consequent in the next cycle.
`define SHRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("split_half_running_statistics: check failed");

`endif

/* rtl/shrs_pkg.sv */
// Package for the split-half running statistics block.
// Holds the request and result types, the sequencer states and fixed constants.
`timescale 1ns / 1ps

package shrs_pkg;

  localparam int unsigned CountW = 13;
  localparam logic [CountW-1:0] MaxSamples = 13'd4096;
  localparam logic [CountW-1:0] TotalSamplesReset = 13'd16;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               restart;
  } shrs_in_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0]        variance;
    logic               variance_valid;
    logic signed [31:0] half_a_mean;
    logic [31:0]        half_a_variance;
    logic               half_a_valid;
    logic signed [31:0] half_b_mean;
    logic [31:0]        half_b_variance;
    logic               half_b_valid;
    logic [CountW-1:0]  sample_count;
  } shrs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_W_START,
    ST_W_DIV,
    ST_W_MUL,
    ST_W_UPD,
    ST_O_START,
    ST_M_DIV,
    ST_V_START,
    ST_V_MUL,
    ST_V_LOAD,
    ST_V_DIV,
    ST_DONE
  } shrs_state_t;

endpackage

/* rtl/split_half_running_statistics.sv */
// Split-half running statistics: Welford trackers for all samples and two halves.
// Depends on shrs_pkg and split_half_running_statistics_macros.svh.
//
//  channel  | signals                          | direction
//  request  | in_valid, in_stall, in_data      | in
//  result   | out_valid, out_stall, out_data   | out
//  config   | cfg_write, cfg_data              | in
//
// Each request runs up to eight divisions through one shared radix-2 divider and uses
// one shared multiplier; a new request is accepted only once the result is taken.
// Reset is synchronous and clears all statistics; the samples-per-pixel register returns to 16.
// in_stall stays high from acceptance until the result is taken.
// A stalled result holds in its output register.
`timescale 1ns / 1ps
`include "split_half_running_statistics_macros.svh"

module split_half_running_statistics
  import shrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  shrs_in_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output shrs_out_t       out_data,
  input  logic            cfg_write,
  input  logic [CountW-1:0] cfg_data
);

  shrs_state_t state, state_next;

  logic [CountW-1:0]  samples_per_pixel;
  logic signed [31:0] x;
  logic               half_sel;
  logic               pass;
  logic [1:0]         ptr;

  logic signed [47:0] sum_r  [3];
  logic [CountW-1:0]  cnt_r  [3];
  logic signed [31:0] mean_r [3];
  logic [63:0]        m2_r   [3];
  logic signed [31:0] res_mean [3];
  logic [31:0]        res_var  [3];

  logic signed [32:0] delta_r;
  logic signed [31:0] nm_r;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_r;

  logic [63:0] dvd;
  logic [25:0] dvs, rem;
  logic [6:0]  div_cnt;
  logic [26:0] trial;

  logic               accept;
  logic               h_now;
  logic signed [32:0] delta_now;
  logic [32:0]        q_mag;
  logic signed [32:0] q_s;
  logic signed [32:0] nm_wide;
  logic signed [32:0] diff_nm;
  logic [32:0]        delta_mag;
  logic [32:0]        diff_mag;
  logic [63:0]        inc;
  logic [64:0]        m2_sum;
  logic [47:0]        sum_mag;

  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                 logic signed [31:0] b);
    logic signed [48:0] r;
    r = {a[47], a} + {{17{b[31]}}, b};
    if (r[48] != r[47]) begin
      sat_add = r[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add = r[47:0];
    end
  endfunction

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign h_now     = (cnt_r[0] < (samples_per_pixel >> 1)) ? 1'b0 : 1'b1;
  assign delta_now = {x[31], x} - {mean_r[ptr][31], mean_r[ptr]};
  assign q_mag     = {1'b0, dvd[31:0]};
  assign q_s       = delta_r[32] ? -$signed(q_mag) : $signed(q_mag);
  assign nm_wide   = {mean_r[ptr][31], mean_r[ptr]} + q_s;
  assign diff_nm   = {x[31], x} - {nm_wide[31], nm_wide[31:0]};
  assign delta_mag = mag33(delta_r);
  assign diff_mag  = mag33(diff_nm);
  assign inc       = {16'd0, prod_r[63:16]};
  assign m2_sum    = {1'b0, m2_r[ptr]} + {1'b0, inc};
  assign sum_mag   = sum_r[ptr][47] ? 48'(-sum_r[ptr]) : 48'(sum_r[ptr]);
  assign trial     = {rem, dvd[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = (cnt_r[0] < MaxSamples) ? ST_W_START : ST_O_START;
      end
      ST_W_START: begin
        if (cnt_r[ptr] != '0) begin
          state_next = ST_W_DIV;
        end else if (pass) begin
          state_next = ST_O_START;
        end
      end
      ST_W_DIV: begin
        if (div_cnt == '0) state_next = ST_W_MUL;
      end
      ST_W_MUL: state_next = ST_W_UPD;
      ST_W_UPD: state_next = pass ? ST_O_START : ST_W_START;
      ST_O_START: state_next = (cnt_r[ptr] != '0) ? ST_M_DIV : ST_V_START;
      ST_M_DIV: begin
        if (div_cnt == '0) state_next = ST_V_START;
      end
      ST_V_START: begin
        if (cnt_r[ptr] >= CountW'(2)) begin
          state_next = ST_V_MUL;
        end else begin
          state_next = (ptr == 2'd2) ? ST_DONE : ST_O_START;
        end
      end
      ST_V_MUL: state_next = ST_V_LOAD;
      ST_V_LOAD: state_next = ST_V_DIV;
      ST_V_DIV: begin
        if (div_cnt == '0) state_next = (ptr == 2'd2) ? ST_DONE : ST_O_START;
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_pixel <= TotalSamplesReset;
      div_cnt <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        mean_r[i] <= '0;
        m2_r[i]   <= '0;
      end
    end else begin
      if (cfg_write) samples_per_pixel <= cfg_data;
      if (div_cnt != '0) begin
        div_cnt <= div_cnt - 7'd1;
        if (!trial[26]) begin
          rem <= trial[25:0];
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= {rem[24:0], dvd[63]};
          dvd <= {dvd[62:0], 1'b0};
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            x <= in_data.sample;
            if (in_data.restart) begin
              for (int i = 0; i < 3; i++) begin
                sum_r[i]  <= '0;
                cnt_r[i]  <= '0;
                mean_r[i] <= '0;
                m2_r[i]   <= '0;
              end
            end
          end
        end
        ST_PREP: begin
          ptr <= 2'd0;
          pass <= 1'b0;
          half_sel <= h_now;
          if (cnt_r[0] < MaxSamples) begin
            sum_r[0] <= sat_add(sum_r[0], x);
            if (h_now) begin
              sum_r[2] <= sat_add(sum_r[2], x);
            end else begin
              sum_r[1] <= sat_add(sum_r[1], x);
            end
          end
        end
        ST_W_START: begin
          if (cnt_r[ptr] == '0) begin
            mean_r[ptr] <= x;
            m2_r[ptr]   <= '0;
            cnt_r[ptr]  <= cnt_r[ptr] + CountW'(1);
            pass <= 1'b1;
            ptr  <= pass ? 2'd0 : (half_sel ? 2'd2 : 2'd1);
          end else begin
            delta_r <= delta_now;
            dvd     <= {31'd0, mag33(delta_now)};
            dvs     <= 26'(cnt_r[ptr]) + 26'd1;
            rem     <= '0;
            div_cnt <= 7'd64;
          end
        end
        ST_W_DIV: begin
          if (div_cnt == '0) begin
            nm_r  <= nm_wide[31:0];
            mul_a <= delta_mag[31:0];
            mul_b <= diff_mag[31:0];
          end
        end
        ST_W_MUL: prod_r <= mul_a * mul_b;
        ST_W_UPD: begin
          mean_r[ptr] <= nm_r;
          m2_r[ptr]   <= m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
          cnt_r[ptr]  <= cnt_r[ptr] + CountW'(1);
          pass <= 1'b1;
          ptr  <= pass ? 2'd0 : (half_sel ? 2'd2 : 2'd1);
        end
        ST_O_START: begin
          res_mean[ptr] <= '0;
          if (cnt_r[ptr] != '0) begin
            dvd     <= {16'd0, sum_mag};
            dvs     <= 26'(cnt_r[ptr]);
            rem     <= '0;
            div_cnt <= 7'd64;
          end
        end
        ST_M_DIV: begin
          if (div_cnt == '0) begin
            if (sum_r[ptr][47]) begin
              res_mean[ptr] <= (dvd[47:0] > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                                 : -$signed(dvd[31:0]);
            end else begin
              res_mean[ptr] <= (dvd[47:0] > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                                 : $signed(dvd[31:0]);
            end
          end
        end
        ST_V_START: begin
          res_var[ptr] <= '0;
          mul_a <= 32'(cnt_r[ptr]);
          mul_b <= 32'(cnt_r[ptr]);
          if (cnt_r[ptr] < CountW'(2)) ptr <= ptr + 2'd1;
        end
        ST_V_MUL: prod_r <= mul_a * mul_b;
        ST_V_LOAD: begin
          dvd     <= m2_r[ptr];
          dvs     <= prod_r[25:0];
          rem     <= '0;
          div_cnt <= 7'd64;
        end
        ST_V_DIV: begin
          if (div_cnt == '0) begin
            res_var[ptr] <= (dvd[63:32] != '0) ? 32'hFFFF_FFFF : dvd[31:0];
            ptr <= ptr + 2'd1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.mean            = res_mean[0];
    out_data.variance        = res_var[0];
    out_data.variance_valid  = (cnt_r[0] >= CountW'(2));
    out_data.half_a_mean     = res_mean[1];
    out_data.half_a_variance = res_var[1];
    out_data.half_a_valid    = (cnt_r[1] >= CountW'(2));
    out_data.half_b_mean     = res_mean[2];
    out_data.half_b_variance = res_var[2];
    out_data.half_b_valid    = (cnt_r[2] >= CountW'(2));
    out_data.sample_count    = cnt_r[0];
  end

  `SHRS_ASSERT_IMP(a_ready_no_result, !in_stall, !out_valid)
  `SHRS_ASSERT_IMP(a_div_only_in_div, div_cnt != '0,
    state == ST_W_DIV || state == ST_M_DIV || state == ST_V_DIV)
  `SHRS_ASSERT_IMP(a_count_limit, 1'b1, cnt_r[0] <= MaxSamples)
  `SHRS_ASSERT_NEXT(a_accept_prep, accept, state == ST_PREP)

endmodule

/* tb/split_half_running_statistics_test.sv */
// Self-checking test for the split-half running statistics block.
// Predicts every result with its own Welford tracker model; depends on shrs_pkg.
`timescale 1ns / 1ps

module split_half_running_statistics_test;
  import shrs_pkg::*;

  localparam longint SumMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;
  localparam int unsigned CycleLimit = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  shrs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  shrs_out_t out_data;
  logic cfg_write = 1'b0;
  logic [CountW-1:0] cfg_data = '0;

  split_half_running_statistics dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  int unsigned  spp;
  longint       all_sum;
  int unsigned  all_count;
  int           trk_mean [3];
  longint unsigned trk_m2 [3];
  int unsigned  trk_count [3];
  longint       part_sum [2];
  int unsigned  part_count [2];

  shrs_out_t expected_stats [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;

  function automatic void clear_stats();
    all_sum = 0;
    all_count = 0;
    for (int i = 0; i < 3; i++) begin
      trk_mean[i] = 0;
      trk_m2[i] = 0;
      trk_count[i] = 0;
    end
    part_sum = '{0, 0};
    part_count = '{0, 0};
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SumMax) return SumMax;
    if (r < SumMin) return SumMin;
    return r;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic void track(int t, int x);
    longint delta;
    longint nm;
    longint unsigned inc;
    if (trk_count[t] == 0) begin
      trk_mean[t] = x;
      trk_m2[t] = 0;
    end else begin
      delta = longint'(x) - longint'(trk_mean[t]);
      nm = longint'(trk_mean[t]) + delta / (longint'(trk_count[t]) + 1);
      inc = (magnitude(delta) * magnitude(longint'(x) - nm)) >> 16;
      trk_mean[t] = int'(nm);
      trk_m2[t] = (trk_m2[t] > 64'hFFFF_FFFF_FFFF_FFFF - inc) ?
                  64'hFFFF_FFFF_FFFF_FFFF : trk_m2[t] + inc;
    end
    trk_count[t]++;
  endfunction

  function automatic logic [31:0] mean_of(longint s, int unsigned n);
    longint m;
    if (n == 0) return '0;
    m = s / longint'(n);
    if (m > 64'sh7FFF_FFFF) m = 64'sh7FFF_FFFF;
    if (m < -64'sh8000_0000) m = -64'sh8000_0000;
    return m[31:0];
  endfunction

  function automatic logic [31:0] variance_of(longint unsigned m2, int unsigned n);
    longint unsigned q;
    if (n < 2) return '0;
    q = m2 / (longint'(n) * longint'(n));
    return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic shrs_out_t predict_stats(shrs_in_t req);
    shrs_out_t r;
    int h;
    if (req.restart) clear_stats();
    if (all_count < MaxSamples) begin
      h = (all_count < spp / 2) ? 0 : 1;
      all_sum = sum_sat(all_sum, req.sample);
      track(0, req.sample);
      part_sum[h] = sum_sat(part_sum[h], req.sample);
      part_count[h]++;
      track(1 + h, req.sample);
      all_count++;
    end
    r.mean = mean_of(all_sum, all_count);
    r.variance = variance_of(trk_m2[0], trk_count[0]);
    r.variance_valid = trk_count[0] >= 2;
    r.half_a_mean = mean_of(part_sum[0], part_count[0]);
    r.half_a_variance = variance_of(trk_m2[1], trk_count[1]);
    r.half_a_valid = trk_count[1] >= 2;
    r.half_b_mean = mean_of(part_sum[1], part_count[1]);
    r.half_b_variance = variance_of(trk_m2[2], trk_count[2]);
    r.half_b_valid = trk_count[2] >= 2;
    r.sample_count = all_count[CountW-1:0];
    return r;
  endfunction

  task automatic send_request(logic signed [31:0] value, logic restart);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_data <= '{sample: value, restart: restart};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_stats.push_back(predict_stats('{sample: value, restart: restart}));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_samples_per_pixel(int unsigned n);
    drain();
    cfg_data <= n[CountW-1:0];
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    spp = n;
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
      2: return $signed($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
      default: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // Stall control and result checking.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else if (out_data !== expected_stats[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_stats[0], out_data);
          void'(expected_stats.pop_front());
        end else begin
          void'(expected_stats.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("** split_half_running_statistics: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(32'sh0001_0000, 1'b1);
    send_request(32'sh7FFF_FFFF, 1'b0);
    send_request(-32'sh8000_0000, 1'b0);
    send_request(32'sh7FFF_FFFF, 1'b0);
    send_request(-32'sh8000_0000, 1'b0);
    send_request(32'sh0000_0000, 1'b0);
    send_request(-32'sh0000_0001, 1'b0);
    send_request(32'sh5555_5555, 1'b0);
    send_request(-32'sh2AAA_AAAB, 1'b0);
    send_request(32'sh0002_0000, 1'b1);
    send_request(32'sh0003_0000, 1'b0);
  endtask

  task automatic test_config_extremes();
    write_samples_per_pixel(1);
    send_request(32'sh0001_0000, 1'b1);
    send_request(32'sh0004_0000, 1'b0);
    send_request(-32'sh0004_0000, 1'b0);
    write_samples_per_pixel(0);
    send_request(32'sh0001_0000, 1'b1);
    send_request(32'sh7FFF_FFFF, 1'b0);
    write_samples_per_pixel(2);
    send_request(32'sh0001_0000, 1'b1);
    send_request(32'sh0002_0000, 1'b0);
    send_request(32'sh0003_0000, 1'b0);
    write_samples_per_pixel(13'h1FFF);
    send_request(-32'sh8000_0000, 1'b1);
    send_request(-32'sh8000_0000, 1'b0);
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_request(rand_sample(), $urandom_range(15) == 0);
  endtask

  task automatic test_idling();
    write_samples_per_pixel(16);
    test_random(200);
    send_idle_pct = 76;
    test_random(100);
    send_idle_pct = 0;
    stall_pct = 76;
    test_random(100);
    send_idle_pct = 28;
    stall_pct = 28;
    write_samples_per_pixel(4096);
    test_random(50);
    write_samples_per_pixel($urandom_range(3, 40));
    test_random(150);
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(5);
    join
    drain();
    test_random(5);
  endtask

  initial begin
    spp = TotalSamplesReset;
    clear_stats();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_idling();
    test_pressure();
    drain();
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("** split_half_running_statistics: PASSED **");
    end else begin
      $display("** split_half_running_statistics: FAILED **");
    end
    $finish;
  end

endmodule
